>>> rtl/core/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// shared constants, command/status types and the divide-by-ten helpers
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int RADIX          = 10;
  localparam int DIGIT_BITS     = 4;

  // reciprocal of ten, exact for every 16-bit operand
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_SCATTER,
    PH_OUT
  } phase_t;

  typedef struct packed {
    logic   load_en;
    logic   load_first;
    logic   rd_en;
    logic   rd_last;
    logic   clear_cnt;
    logic   prefix_en;
    digit_t prefix_idx;
    logic   flip;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic lq_zero;
    logic out_room;
  } sts_t;

  function automatic logic [FIELD_BITS-1:0] div10(input logic [FIELD_BITS-1:0] q);
    logic [32:0] p;
    p = 33'(q) * 33'(DIV10_MUL);
    return FIELD_BITS'(p >> DIV10_SHIFT);
  endfunction

  function automatic digit_t mod10(input logic [FIELD_BITS-1:0] q,
                                   input logic [FIELD_BITS-1:0] q10);
    logic [FIELD_BITS-1:0] t;
    t = q - {q10[FIELD_BITS-4:0], 3'b000} - {q10[FIELD_BITS-2:0], 1'b0};
    return t[DIGIT_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/drs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_ctrl
// sequencer: load, digit count, prefix sum, scatter, flip and output sweeps
// ----------------------------------------------------------------------------
module drs_ctrl #(
  parameter int MAX_ITEMS = drs_pkg::MAX_ITEMS_DEF,
  localparam int AW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_stall,
  input  drs_pkg::sts_t  sts,
  output drs_pkg::cmd_t  cmd,
  output logic [AW-1:0]  rd_addr,
  output logic [AW-1:0]  load_addr
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_COUNT,
    S_CNT_DRAIN,
    S_PREFIX,
    S_SCATTER,
    S_SCT_DRAIN,
    S_FLIP,
    S_OUTPUT,
    S_OUT_DRAIN
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   idx;
  drs_pkg::digit_t pidx;

  logic            in_accept;
  logic            closing;
  logic [CW-1:0]   count_m1;
  logic [AW-1:0]   last_idx;

  assign in_stall  = (state != S_LOAD);
  assign in_accept = in_valid && (state == S_LOAD);
  assign closing   = in_last || (count == CW'(MAX_ITEMS - 1));
  assign count_m1  = count - CW'(1);
  assign last_idx  = count_m1[AW-1:0];
  assign rd_addr   = idx;
  assign load_addr = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      idx   <= '0;
      pidx  <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_accept) begin
            count <= count + CW'(1);
            if (closing) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (sts.lq_zero) state <= S_OUTPUT;
          else state <= S_COUNT;
        end
        S_COUNT: begin
          idx <= idx + AW'(1);
          if (idx == last_idx) state <= S_CNT_DRAIN;
        end
        S_CNT_DRAIN: begin
          if (!sts.busy) begin
            pidx  <= '0;
            state <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          pidx <= pidx + drs_pkg::digit_t'(1);
          if (pidx == drs_pkg::digit_t'(drs_pkg::RADIX - 1)) begin
            idx   <= last_idx;
            state <= S_SCATTER;
          end
        end
        S_SCATTER: begin
          idx <= idx - AW'(1);
          if (idx == '0) state <= S_SCT_DRAIN;
        end
        S_SCT_DRAIN: begin
          if (!sts.busy) state <= S_FLIP;
        end
        S_FLIP: begin
          state <= S_CHECK;
        end
        S_OUTPUT: begin
          if (sts.out_room) begin
            idx <= idx + AW'(1);
            if (idx == last_idx) state <= S_OUT_DRAIN;
          end
        end
        S_OUT_DRAIN: begin
          if (!sts.busy) begin
            count <= '0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.phase = drs_pkg::PH_IDLE;
    cmd.prefix_idx = pidx;
    case (state)
      S_LOAD: begin
        cmd.load_en    = in_accept;
        cmd.load_first = (count == '0);
      end
      S_CHECK: begin
        cmd.clear_cnt = !sts.lq_zero;
      end
      S_COUNT: begin
        cmd.rd_en = 1'b1;
        cmd.phase = drs_pkg::PH_COUNT;
      end
      S_CNT_DRAIN: begin
        cmd.phase = drs_pkg::PH_COUNT;
      end
      S_PREFIX: begin
        cmd.prefix_en = 1'b1;
      end
      S_SCATTER: begin
        cmd.rd_en = 1'b1;
        cmd.phase = drs_pkg::PH_SCATTER;
      end
      S_SCT_DRAIN: begin
        cmd.phase = drs_pkg::PH_SCATTER;
      end
      S_FLIP: begin
        cmd.flip = 1'b1;
      end
      S_OUTPUT: begin
        cmd.rd_en   = sts.out_room;
        cmd.rd_last = (idx == last_idx);
        cmd.phase   = drs_pkg::PH_OUT;
      end
      S_OUT_DRAIN: begin
        cmd.phase = drs_pkg::PH_OUT;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/drs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_datapath
// ping-pong element stores, digit pipeline, bucket counters, output queue
// ----------------------------------------------------------------------------
module drs_datapath #(
  parameter int MAX_ITEMS  = drs_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = drs_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1),
  localparam int SB = (VALUE_BITS < drs_pkg::FIELD_BITS) ? VALUE_BITS : drs_pkg::FIELD_BITS,
  localparam int EW = 2 * SB
) (
  input  logic                           clk,
  input  logic                           rst,
  input  drs_pkg::cmd_t                  cmd,
  output drs_pkg::sts_t                  sts,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [AW-1:0]                  load_addr,
  input  logic [drs_pkg::FIELD_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [drs_pkg::FIELD_BITS-1:0] sorted_value,
  output logic                           last_res
);

  // each entry holds {value, value / weight}
  logic [EW-1:0] mem_a [MAX_ITEMS];
  logic [EW-1:0] mem_b [MAX_ITEMS];
  logic [EW-1:0] rd_a, rd_b;
  logic          sel;

  logic                  s1_valid, s1_last;
  drs_pkg::phase_t       s1_phase;
  logic [EW-1:0]         s1_data;
  logic [drs_pkg::FIELD_BITS-1:0] s1_q, s1_q10;
  drs_pkg::digit_t       s1_digit;

  logic                  s2_valid;
  drs_pkg::phase_t       s2_phase;
  drs_pkg::digit_t       s2_digit;
  logic [SB-1:0]         s2_value, s2_q10;

  logic [CW-1:0]         cnt [drs_pkg::RADIX];
  logic [CW-1:0]         acc;
  logic [CW-1:0]         pos_full;
  logic [AW-1:0]         s2_pos;
  logic                  sct_we;

  logic [SB-1:0]         largest;
  logic [SB-1:0]         load_val;

  logic                  we_a, we_b;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  logic [SB-1:0]         q_val  [2];
  logic                  q_last [2];
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            occ, level;
  logic                  push, pop;

  assign load_val = in_value[SB-1:0];

  // store write port: load into the live store, scatter into the other one
  assign pos_full = cnt[s2_digit] - CW'(1);
  assign s2_pos   = pos_full[AW-1:0];
  assign sct_we   = s2_valid && (s2_phase == drs_pkg::PH_SCATTER);
  assign we_a     = (cmd.load_en && !sel) || (sct_we && sel);
  assign we_b     = (cmd.load_en && sel) || (sct_we && !sel);
  assign wr_addr  = cmd.load_en ? load_addr : s2_pos;
  assign wr_data  = cmd.load_en ? {load_val, load_val} : {s2_value, s2_q10};

  always_ff @(posedge clk) begin
    if (we_a) mem_a[wr_addr] <= wr_data;
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wr_addr] <= wr_data;
    rd_b <= mem_b[rd_addr];
  end

  // digit of the stored quotient and the quotient for the next weight
  assign s1_data  = sel ? rd_b : rd_a;
  assign s1_q     = drs_pkg::FIELD_BITS'(s1_data[SB-1:0]);
  assign s1_q10   = drs_pkg::div10(s1_q);
  assign s1_digit = drs_pkg::mod10(s1_q, s1_q10);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
    s1_last  <= cmd.rd_last;
    s1_phase <= cmd.phase;
    s2_phase <= s1_phase;
    s2_digit <= s1_digit;
    s2_value <= s1_data[EW-1:SB];
    s2_q10   <= s1_q10[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_cnt) begin
      for (int k = 0; k < drs_pkg::RADIX; k++) cnt[k] <= '0;
      acc <= '0;
    end else if (cmd.prefix_en) begin
      cnt[cmd.prefix_idx] <= acc + cnt[cmd.prefix_idx];
      acc                 <= acc + cnt[cmd.prefix_idx];
    end else if (s2_valid && (s2_phase == drs_pkg::PH_COUNT)) begin
      cnt[s2_digit] <= cnt[s2_digit] + CW'(1);
    end else if (sct_we) begin
      cnt[s2_digit] <= pos_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= 1'b0;
      largest <= '0;
    end else begin
      if (cmd.load_en && (cmd.load_first || (load_val > largest))) largest <= load_val;
      if (cmd.flip) begin
        sel     <= ~sel;
        largest <= SB'(drs_pkg::div10(drs_pkg::FIELD_BITS'(largest)));
      end
    end
  end

  // two-entry output queue
  assign push      = s1_valid && (s1_phase == drs_pkg::PH_OUT);
  assign out_valid = (occ != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign level     = occ + {1'b0, push};

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      occ <= occ + {1'b0, push} - {1'b0, pop};
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
    if (push) begin
      q_val[wr_ptr]  <= s1_data[EW-1:SB];
      q_last[wr_ptr] <= s1_last;
    end
  end

  assign sorted_value = drs_pkg::FIELD_BITS'(q_val[rd_ptr]);
  assign last_res     = q_last[rd_ptr];

  assign sts.busy     = s1_valid || s2_valid;
  assign sts.lq_zero  = (largest == '0);
  assign sts.out_room = (level < 2'd2) || ((level == 2'd2) && pop);

endmodule

>>> rtl/core/decimal_radix_sorter_core.sv
`timescale 1ns / 1ps
// load: one beat per cycle; the set closes on last or when MAX_ITEMS are held
// sort: one pass per decimal digit of the largest value, then a last test
//   (pass: test, count sweep, 10 prefix steps, scatter sweep, two drains, flip)
// output: after the sort, one beat per cycle unstalled
// input stalls after the closing beat until the last read has left the pipeline
// reset (rst, synchronous) clears control state; the element stores need none
// ----------------------------------------------------------------------------
// decimal_radix_sorter_core
// base-ten lsd radix sorter with ping-pong element stores
// ----------------------------------------------------------------------------
module decimal_radix_sorter_core #(
  parameter int MAX_ITEMS  = drs_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = drs_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [drs_pkg::FIELD_BITS-1:0] value,
  input  logic                           last,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [drs_pkg::FIELD_BITS-1:0] sorted_value,
  output logic                           last_res
);

  localparam int AW = $clog2(MAX_ITEMS);

  drs_pkg::cmd_t cmd;
  drs_pkg::sts_t sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] load_addr;

  // sequencer: element count, sweep index and pass ordering
  drs_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .load_addr(load_addr)
  );

  // stores, digit pipeline, bucket counters and the output queue; the queue
  // parts the result beat from the sweep so the store can be reloaded while
  // the final beats still wait
  drs_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .rd_addr     (rd_addr),
    .load_addr   (load_addr),
    .in_value    (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .last_res    (last_res)
  );

endmodule

>>> rtl/core/drs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_checker
// port-level checks on stalled result hold, ordering, run length and closing behaviour
// ----------------------------------------------------------------------------
module drs_checker #(
  parameter int MAX_ITEMS = drs_pkg::MAX_ITEMS_DEF,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           last,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [drs_pkg::FIELD_BITS-1:0] sorted_value,
  input logic                           last_res
);

  logic                           in_run;
  logic [CW-1:0]                  run_cnt;
  logic [drs_pkg::FIELD_BITS-1:0] prev_val;
  logic                           out_beat;
  logic                           in_beat;

  assign out_beat = out_valid && !out_stall;
  assign in_beat  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run  <= 1'b0;
      run_cnt <= '0;
    end else if (out_beat) begin
      if (last_res) begin
        in_run  <= 1'b0;
        run_cnt <= '0;
      end else begin
        in_run  <= 1'b1;
        run_cnt <= run_cnt + CW'(1);
      end
    end
    if (out_beat) prev_val <= sorted_value;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(last_res))
    else $error("stalled result beat changed");

  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    in_beat && last |=> in_stall)
    else $error("input not stalled after closing beat");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_beat && in_run |-> sorted_value >= prev_val)
    else $error("result beats out of order");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    out_beat && (run_cnt == CW'(MAX_ITEMS - 1)) |-> last_res)
    else $error("run longer than the store");

endmodule

bind decimal_radix_sorter_core drs_checker #(.MAX_ITEMS(MAX_ITEMS)) u_drs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .last        (last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sorted_value(sorted_value),
  .last_res    (last_res)
);
